// File: design/rbc_pkg.sv
`timescale 1ns / 1ps

package rbc_pkg;

    // Table geometry
    localparam int MAX_RANGES_DEF = 16;

    // Field widths
    localparam int VAL_W   = 64;
    localparam int SLOT_W  = 4;
    localparam int LABEL_W = 4;
    localparam int COUNT_W = 5;
    localparam int CFG_IDX_W = 2;

    // Action codes of an input item
    typedef enum logic {
        ACT_WRITE    = 1'b0,
        ACT_CLASSIFY = 1'b1
    } t_action;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RANGE_COUNT = 2'd0,
        CFG_OPEN_LEFT   = 2'd1,
        CFG_OPEN_RIGHT  = 2'd2
    } t_cfg_idx;

    // One table entry as held in the memory
    typedef struct packed {
        logic [VAL_W-1:0]   low;
        logic [VAL_W-1:0]   high;
        logic [LABEL_W-1:0] label;
    } t_entry;

endpackage

// File: design/rbc_ram.sv
`timescale 1ns / 1ps

module rbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/range_bucket_classifier.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                   Carries
// input     in         i_in_valid / o_in_stall     action, slot, bounds, label, sample
// output    out        o_out_valid / i_out_stall   bucket
// config    in         i_cfg_valid / o_cfg_ready   register index, data
//
// A write item goes straight into the table memory.
// A classify item reads the first and the last entry, applies the end rules and,
// unless an end rule settles it, scans the entries in order to the clamped count.
// The scan is paced by the single read port of the table memory, one entry a cycle.
// The next item is taken in the cycle after the result register is loaded.
// Synchronous active-low reset resets control state and config registers; the table
// itself is undefined until written. A result waiting in the output register does
// not stop the next item from being accepted; only a full result path does.

module range_bucket_classifier #(
    parameter int MAX_RANGES = rbc_pkg::MAX_RANGES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input items
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_action,
    input  logic [rbc_pkg::SLOT_W-1:0]    i_slot,
    input  logic signed [rbc_pkg::VAL_W-1:0] i_range_low,
    input  logic signed [rbc_pkg::VAL_W-1:0] i_range_high,
    input  logic [rbc_pkg::LABEL_W-1:0]   i_bucket_label,
    input  logic signed [rbc_pkg::VAL_W-1:0] i_sample,
    // result items
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [rbc_pkg::COUNT_W-1:0]   o_bucket,
    // configuration writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rbc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rbc_pkg::COUNT_W-1:0]   i_cfg_data
);

    import rbc_pkg::*;

    localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam logic [AW-1:0] LAST_MAX = AW'(MAX_RANGES - 1);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_LAST = 5'b00010,
        ST_ENDS = 5'b00100,
        ST_SCAN = 5'b01000,
        ST_DONE = 5'b10000
    } t_state;

    // Control and configuration
    t_state               r_state, n_state;
    logic [COUNT_W-1:0]   r_range_count;
    logic                 r_open_left;
    logic                 r_open_right;
    logic [AW-1:0]        r_idx, n_idx;
    logic [COUNT_W-1:0]   r_result, n_result;
    logic                 r_out_valid, n_out_valid;
    logic [COUNT_W-1:0]   r_bucket, n_bucket;

    // Payload held for the item in work
    logic signed [VAL_W-1:0] r_sample;
    t_entry               r_first;

    // Memory ports
    logic                 ram_we;
    logic [AW-1:0]        ram_raddr;
    t_entry               wr_entry;
    t_entry               rd_entry;

    logic                 in_acc;
    logic                 out_free;
    logic [AW-1:0]        last_idx;
    logic signed [VAL_W-1:0] rd_low, rd_high, first_low, first_high;
    logic                 below_first_high, below_first_low;
    logic                 below_last_low, below_last_high;
    logic                 scan_hit;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_count <= COUNT_W'(1);
            r_open_left   <= 1'b0;
            r_open_right  <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_RANGE_COUNT: r_range_count <= i_cfg_data;
                CFG_OPEN_LEFT:   r_open_left   <= i_cfg_data[0];
                CFG_OPEN_RIGHT:  r_open_right  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Last scanned entry: count clamped to [1, MAX_RANGES]
    always_comb begin
        if (r_range_count == '0) begin
            last_idx = '0;
        end else if (32'(r_range_count) > MAX_RANGES) begin
            last_idx = LAST_MAX;
        end else begin
            last_idx = AW'(r_range_count - COUNT_W'(1));
        end
    end

    // Table memory; writes only happen while idle, so no scan read can overlap them
    assign wr_entry.low   = i_range_low;
    assign wr_entry.high  = i_range_high;
    assign wr_entry.label = i_bucket_label;
    assign ram_we = in_acc && (i_action == ACT_WRITE) && (32'(i_slot) < MAX_RANGES);

    always_comb begin
        case (r_state)
            ST_LAST: ram_raddr = last_idx;
            ST_SCAN: ram_raddr = r_idx + AW'(1);
            default: ram_raddr = '0;
        endcase
    end

    rbc_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_RANGES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(i_slot)),
        .i_wdata (wr_entry),
        .i_raddr (ram_raddr),
        .o_rdata (rd_entry)
    );

    // Comparisons against the sample
    assign rd_low     = $signed(rd_entry.low);
    assign rd_high    = $signed(rd_entry.high);
    assign first_low  = $signed(r_first.low);
    assign first_high = $signed(r_first.high);

    assign below_first_high = r_sample < first_high;
    assign below_first_low  = r_sample < first_low;
    assign below_last_low   = r_sample < rd_low;
    assign below_last_high  = r_sample < rd_high;
    assign scan_hit         = !below_last_low && below_last_high;

    // Sequencer: first entry, last entry, end rules, then an in-order scan unless an end rule settles it
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_result    = r_result;
        n_out_valid = r_out_valid && i_out_stall;
        n_bucket    = r_bucket;
        case (r_state)
            ST_IDLE: begin
                // entry 0 is read every idle cycle
                if (in_acc && (i_action == ACT_CLASSIFY)) begin
                    n_state = ST_LAST;
                end
            end
            ST_LAST: begin
                n_state = ST_ENDS;
            end
            ST_ENDS: begin
                n_idx = '0;
                if (r_open_left && below_first_high) begin
                    n_result = COUNT_W'(r_first.label);
                    n_state  = ST_DONE;
                end else if (r_open_right && !below_last_low) begin
                    n_result = COUNT_W'(rd_entry.label);
                    n_state  = ST_DONE;
                end else if (!r_open_left && below_first_low) begin
                    n_result = r_range_count;
                    n_state  = ST_DONE;
                end else if (!r_open_right && !below_last_high) begin
                    n_result = r_range_count;
                    n_state  = ST_DONE;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // rd_entry holds entry r_idx here
                if (scan_hit) begin
                    n_result = COUNT_W'(rd_entry.label);
                    n_state  = ST_DONE;
                end else if (r_idx == last_idx) begin
                    n_result = r_range_count;
                    n_state  = ST_DONE;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_bucket    = r_result;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        r_bucket <= n_bucket;
        if (in_acc) begin
            r_sample <= i_sample;
        end
        if (r_state == ST_LAST) begin
            r_first <= rd_entry;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_bucket    = r_bucket;

    // Checks
    a_classify_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_action == ACT_CLASSIFY)) |=> (r_state == ST_LAST))
        else $error("classify item did not start a table read");

    a_write_idle_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == ST_IDLE))
        else $error("table written while a classify item is in work");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_idx <= last_idx))
        else $error("scan ran past the last entry");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_out_valid && !(r_out_valid && i_out_stall)) |-> (r_state == ST_DONE))
        else $error("result loaded outside the done step");

endmodule

// File: dv/range_bucket_classifier_test.sv
`timescale 1ns / 1ps

module range_bucket_classifier_test;
    import rbc_pkg::*;

    localparam int  SETTLE_CYCLES = 32;     // longest classify with margin
    localparam int  PHASES        = 12;
    localparam int  PHASE_CLASSIFY = 134;   // plus a 16-entry reload in most phases
    localparam int  LONG_HOLD     = 400;
    localparam int  MAX_SHOWN     = 100;
    localparam logic signed [VAL_W-1:0] S64_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] S64_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic { ROW_ITEM, ROW_REG } t_row_kind;

    // One line of the directed stimulus
    typedef struct {
        t_row_kind               kind;
        logic [CFG_IDX_W-1:0]    reg_idx;
        logic [COUNT_W-1:0]      reg_data;
        t_action                 act;
        logic [SLOT_W-1:0]       slot;
        logic signed [VAL_W-1:0] lo;
        logic signed [VAL_W-1:0] hi;
        logic [LABEL_W-1:0]      lab;
        logic signed [VAL_W-1:0] smp;
        bit                      typed;
        logic [COUNT_W-1:0]      typed_bucket;
    } t_step_row;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic                          i_action;
    logic [SLOT_W-1:0]             i_slot;
    logic signed [VAL_W-1:0]       i_range_low;
    logic signed [VAL_W-1:0]       i_range_high;
    logic [LABEL_W-1:0]            i_bucket_label;
    logic signed [VAL_W-1:0]       i_sample;
    logic                          o_out_valid;
    logic                          i_out_stall;
    logic [COUNT_W-1:0]            o_bucket;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [CFG_IDX_W-1:0]          i_cfg_index;
    logic [COUNT_W-1:0]            i_cfg_data;

    // Shadow of the table and registers
    logic signed [VAL_W-1:0] lo_tab  [MAX_RANGES_DEF];
    logic signed [VAL_W-1:0] hi_tab  [MAX_RANGES_DEF];
    logic [LABEL_W-1:0]      lab_tab [MAX_RANGES_DEF];
    logic [COUNT_W-1:0]      count_sh      = 5'd1;
    logic                    open_left_sh  = 1'b0;
    logic                    open_right_sh = 1'b0;

    logic [COUNT_W-1:0] pending_buckets [$];
    t_step_row          dir_rows [$];
    int                 mismatch_count = 0;
    bit                 brisk = 1'b0;   // no random idling on either side while set; the long hold-offs still apply

    range_bucket_classifier u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_slot         (i_slot),
        .i_range_low    (i_range_low),
        .i_range_high   (i_range_high),
        .i_bucket_label (i_bucket_label),
        .i_sample       (i_sample),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_bucket       (o_bucket),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #(2_000_000);
        $display("TB_ERROR");
        $finish;
    end

    task automatic flag_mismatch(string what, logic [COUNT_W-1:0] got,
                                 logic [COUNT_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
            $display("mismatch at %0t: %s, got %0d, want %0d", $time, what, got, want);
    endtask

    // Entries scanned: range count clamped to 1..MAX_RANGES
    function automatic int scan_len();
        int n;
        n = int'(count_sh);
        if (n < 1) n = 1;
        if (n > MAX_RANGES_DEF) n = MAX_RANGES_DEF;
        return n;
    endfunction

    // Bucket a sample falls into under the current table and registers
    function automatic logic [COUNT_W-1:0] predict_bucket(logic signed [VAL_W-1:0] s);
        int n;
        int last;
        n    = scan_len();
        last = n - 1;
        if (open_left_sh && s < hi_tab[0])
            return COUNT_W'(lab_tab[0]);
        if (open_right_sh && !(s < lo_tab[last]))
            return COUNT_W'(lab_tab[last]);
        if (!open_left_sh && s < lo_tab[0])
            return count_sh;
        if (!open_right_sh && !(s < hi_tab[last]))
            return count_sh;
        for (int i = 0; i < n; i++)
            if (!(s < lo_tab[i]) && s < hi_tab[i])
                return COUNT_W'(lab_tab[i]);
        return count_sh;
    endfunction

    // Samples aimed at the bounds of scanned entries, with some anywhere
    function automatic logic signed [VAL_W-1:0] pick_sample();
        int k;
        logic [VAL_W-1:0] span;
        k = $urandom_range(0, scan_len() - 1);
        case ($urandom_range(0, 9))
            0: return {$urandom, $urandom};
            1: return S64_MIN;
            2: return S64_MAX;
            3: return lo_tab[k];
            4: return lo_tab[k] - 1;
            5: return hi_tab[k];
            6: return hi_tab[k] - 1;
            default: begin
                span = hi_tab[k] - lo_tab[k];
                if (span == 0)
                    return lo_tab[k];
                return lo_tab[k] + ({$urandom, $urandom} % span);
            end
        endcase
    endfunction

    // Offer one item and wait for it to be taken
    task automatic send_item(t_action act, logic [SLOT_W-1:0] slot,
                             logic signed [VAL_W-1:0] lo, logic signed [VAL_W-1:0] hi,
                             logic [LABEL_W-1:0] lab, logic signed [VAL_W-1:0] smp,
                             bit typed, logic [COUNT_W-1:0] typed_bucket);
        int gap;
        gap = brisk ? 0 : $urandom_range(0, 19);
        i_cfg_valid <= 1'b0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_action       <= act;
        i_slot         <= slot;
        i_range_low    <= lo;
        i_range_high   <= hi;
        i_bucket_label <= lab;
        i_sample       <= smp;
        do @(posedge i_clk); while (o_in_stall);
        if (act == ACT_WRITE) begin
            if (int'(slot) < MAX_RANGES_DEF) begin
                lo_tab[slot]  = lo;
                hi_tab[slot]  = hi;
                lab_tab[slot] = lab;
            end
        end else begin
            pending_buckets.push_back(typed ? typed_bucket : predict_bucket(smp));
        end
    endtask

    // Register write; valid stays up so back-to-back writes need no extra edge
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COUNT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_RANGE_COUNT: count_sh      = data;
            CFG_OPEN_LEFT:   open_left_sh  = data[0];
            CFG_OPEN_RIGHT:  open_right_sh = data[0];
            default: ;
        endcase
    endtask

    // Wait for every result, then let any trailing write finish
    task automatic drain_block();
        i_in_valid  <= 1'b0;
        i_cfg_valid <= 1'b0;
        while (pending_buckets.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Fill all slots with ascending ranges: contiguous, gapped, overlapping or empty
    task automatic reload_table();
        logic signed [VAL_W-1:0] mark;
        logic signed [VAL_W-1:0] lo_new [MAX_RANGES_DEF];
        logic signed [VAL_W-1:0] hi_new [MAX_RANGES_DEF];
        logic [VAL_W-1:0]        stride_cap;
        logic [VAL_W-1:0]        w;
        int                      shape;
        int                      how;
        int                      n;
        shape = $urandom_range(0, 3);
        if ($urandom_range(0, 1) == 1) begin
            mark       = S64_MIN + ({$urandom, $urandom} >> 3);
            stride_cap = 64'h1 << 58;
        end else begin
            mark       = -VAL_W'($urandom_range(0, 2000));
            stride_cap = VAL_W'($urandom_range(1, 60));
        end
        for (int i = 0; i < MAX_RANGES_DEF; i++) begin
            w         = ({$urandom, $urandom} % stride_cap) + 1;
            lo_new[i] = mark;
            hi_new[i] = mark + w;
            how = (shape == 3) ? $urandom_range(0, 3) : shape;
            case (how)
                0: mark = hi_new[i];
                1: mark = hi_new[i] + ({$urandom, $urandom} % stride_cap) + 1;
                2: mark = mark + (w >> 1);
                default: begin
                    hi_new[i] = lo_new[i];
                    mark      = mark + w;
                end
            endcase
        end
        // Outer bounds at the ends of the number line now and then
        n = scan_len();
        if ($urandom_range(0, 2) == 0) lo_new[0] = S64_MIN;
        if ($urandom_range(0, 2) == 0) hi_new[n-1] = S64_MAX;
        for (int i = 0; i < MAX_RANGES_DEF; i++)
            send_item(ACT_WRITE, SLOT_W'(i), lo_new[i], hi_new[i],
                      LABEL_W'($urandom_range(0, 15)), {$urandom, $urandom}, 1'b0, '0);
    endtask

    task automatic add_item_row(t_action act, logic [SLOT_W-1:0] slot,
                                logic signed [VAL_W-1:0] lo, logic signed [VAL_W-1:0] hi,
                                logic [LABEL_W-1:0] lab, logic signed [VAL_W-1:0] smp,
                                bit typed, logic [COUNT_W-1:0] typed_bucket);
        t_step_row r;
        r = '{ROW_ITEM, '0, '0, act, slot, lo, hi, lab, smp, typed, typed_bucket};
        dir_rows.push_back(r);
    endtask

    task automatic add_reg_row(logic [CFG_IDX_W-1:0] idx, logic [COUNT_W-1:0] data);
        t_step_row r;
        r = '{ROW_REG, idx, data, ACT_WRITE, '0, '0, '0, '0, '0, 1'b0, '0};
        dir_rows.push_back(r);
    endtask

    // Result side: random stall per item, two long hold-offs
    initial begin : result_sink
        int taken;
        int hold;
        taken = 0;
        forever begin
            if (taken == 150 || taken == 800)
                hold = LONG_HOLD;
            else if (brisk)
                hold = 0;
            else
                hold = $urandom_range(0, 19);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
            taken++;
        end
    end

    // Compare each taken result with the oldest expected bucket
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_buckets.size() == 0) begin
                flag_mismatch("result with none expected", o_bucket, '0);
            end else begin
                if (o_bucket !== pending_buckets[0])
                    flag_mismatch("bucket", o_bucket, pending_buckets[0]);
                void'(pending_buckets.pop_front());
            end
        end
    end

    // Stimulus
    initial begin : stimulus
        int                 p;
        int                 k;
        logic [COUNT_W-1:0] cnt_pick;
        logic               ol_pick;
        logic               or_pick;

        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_action       <= ACT_WRITE;
        i_slot         <= '0;
        i_range_low    <= '0;
        i_range_high   <= '0;
        i_bucket_label <= '0;
        i_sample       <= '0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= CFG_RANGE_COUNT;
        i_cfg_data     <= '0;
        for (int i = 0; i < MAX_RANGES_DEF; i++) begin
            lo_tab[i]  = '0;
            hi_tab[i]  = '0;
            lab_tab[i] = '0;
        end

        // Directed rows; only entry 0 (and later 1) is ever scanned here
        add_item_row(ACT_WRITE, 4'd0, -64'sd100, 64'sd100, 4'd7, '0, 1'b0, '0);
        add_item_row(ACT_CLASSIFY, 4'hF, S64_MAX, S64_MIN, 4'hF, -64'sd100, 1'b1, 5'd7);
        add_item_row(ACT_CLASSIFY, '0, '0, '0, '0, 64'sd99, 1'b1, 5'd7);
        // no match gives the reset range count
        add_item_row(ACT_CLASSIFY, '0, '0, '0, '0, 64'sd100, 1'b1, 5'd1);
        add_item_row(ACT_CLASSIFY, '0, '0, '0, '0, S64_MIN, 1'b1, 5'd1);
        add_item_row(ACT_CLASSIFY, '0, '0, '0, '0, S64_MAX, 1'b1, 5'd1);
        // count of zero: still scans entry 0, no-match code is 0
        add_reg_row(CFG_RANGE_COUNT, 5'd0);
        add_item_row(ACT_CLASSIFY, '0, '0, '0, '0, '0, 1'b1, 5'd7);
        add_item_row(ACT_CLASSIFY, '0, '0, '0, '0, 64'sd100, 1'b1, 5'd0);
        // open left end
        add_reg_row(CFG_OPEN_LEFT, 5'd1);
        add_item_row(ACT_CLASSIFY, '0, '0, '0, '0, S64_MIN, 1'b1, 5'd7);
        add_item_row(ACT_CLASSIFY, '0, '0, '0, '0, 64'sd200, 1'b1, 5'd0);
        // open right end
        add_reg_row(CFG_OPEN_RIGHT, 5'd1);
        add_item_row(ACT_CLASSIFY, '0, '0, '0, '0, S64_MAX, 1'b1, 5'd7);
        // two entries, closed ends, extreme bounds
        add_item_row(ACT_WRITE, 4'd1, 64'sd100, S64_MAX, 4'd15, '0, 1'b0, '0);
        add_reg_row(CFG_RANGE_COUNT, 5'd2);
        add_reg_row(CFG_OPEN_LEFT, 5'd0);
        add_reg_row(CFG_OPEN_RIGHT, 5'd0);
        add_item_row(ACT_CLASSIFY, '0, '0, '0, '0, 64'sd100, 1'b0, '0);
        add_item_row(ACT_CLASSIFY, '0, '0, '0, '0, S64_MAX, 1'b1, 5'd2);
        add_item_row(ACT_WRITE, 4'd0, S64_MIN, -64'sd5, 4'd0, S64_MAX, 1'b0, '0);
        add_item_row(ACT_CLASSIFY, '0, '0, '0, '0, -64'sd5, 1'b0, '0);
        add_item_row(ACT_CLASSIFY, '0, '0, '0, '0, S64_MIN, 1'b0, '0);
        // unused register index must leave everything alone
        add_reg_row(CFG_UNUSED, 5'h1F);
        add_item_row(ACT_CLASSIFY, '0, '0, '0, '0, 64'sd50, 1'b1, 5'd2);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_REG) begin
                drain_block();
                write_reg(dir_rows[r].reg_idx, dir_rows[r].reg_data);
            end else begin
                send_item(dir_rows[r].act, dir_rows[r].slot, dir_rows[r].lo, dir_rows[r].hi,
                          dir_rows[r].lab, dir_rows[r].smp, dir_rows[r].typed,
                          dir_rows[r].typed_bucket);
            end
        end

        // Random phases: new settings, a table reload or one to three writes, then mostly classify items
        for (p = 0; p < PHASES; p++) begin
            drain_block();
            brisk = (p % 4 == 3);
            case (p)
                0: begin cnt_pick = 5'd31; ol_pick = 1'b0; or_pick = 1'b0; end
                1: begin cnt_pick = 5'd16; ol_pick = 1'b1; or_pick = 1'b1; end
                2: begin cnt_pick = 5'd0;  ol_pick = 1'b1; or_pick = 1'b0; end
                3: begin cnt_pick = 5'd1;  ol_pick = 1'b0; or_pick = 1'b1; end
                4: begin cnt_pick = 5'd17; ol_pick = 1'b1; or_pick = 1'b1; end
                default: begin
                    case ($urandom_range(0, 7))
                        0: cnt_pick = 5'd0;
                        1: cnt_pick = 5'd31;
                        2: cnt_pick = 5'd16;
                        3: cnt_pick = COUNT_W'($urandom_range(17, 30));
                        default: cnt_pick = COUNT_W'($urandom_range(1, 16));
                    endcase
                    ol_pick = $urandom_range(0, 1);
                    or_pick = $urandom_range(0, 1);
                end
            endcase
            write_reg(CFG_RANGE_COUNT, cnt_pick);
            // upper data bits are don't-care for the one-bit registers
            write_reg(CFG_OPEN_LEFT, {4'($urandom_range(0, 15)), ol_pick});
            write_reg(CFG_OPEN_RIGHT, {4'($urandom_range(0, 15)), or_pick});
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_UNUSED, COUNT_W'($urandom_range(0, 31)));

            if (p == 0 || $urandom_range(0, 3) != 0) begin
                reload_table();
            end else begin
                repeat ($urandom_range(1, 3))
                    send_item(ACT_WRITE, SLOT_W'($urandom_range(0, 15)),
                              {$urandom, $urandom}, {$urandom, $urandom},
                              LABEL_W'($urandom_range(0, 15)), {$urandom, $urandom},
                              1'b0, '0);
            end

            for (k = 0; k < PHASE_CLASSIFY; k++) begin
                if ($urandom_range(0, 15) == 0)
                    send_item(ACT_WRITE, SLOT_W'($urandom_range(0, 15)),
                              {$urandom, $urandom}, {$urandom, $urandom},
                              LABEL_W'($urandom_range(0, 15)), {$urandom, $urandom},
                              1'b0, '0);
                else
                    send_item(ACT_CLASSIFY, SLOT_W'($urandom_range(0, 15)),
                              {$urandom, $urandom}, {$urandom, $urandom},
                              LABEL_W'($urandom_range(0, 15)), pick_sample(), 1'b0, '0);
            end
        end

        drain_block();
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
